@@ hw/rtl/mev_pkg.sv @@
// ----------------------------------------------------------------------------
// mev_pkg: shared types and constants of the masked event queue
// Queue geometry, action and sequencer codes, slot and response layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package mev_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int KIND_W = 5;
   localparam int WORD_W = 32;
   localparam int POS_W  = 16;

   // request tdata: kind, message, select mask, stop mask, tick, mouse h, mouse v
   localparam int REQ_BITS   = KIND_W + 4 * WORD_W + 2 * POS_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int ACT_W      = 2;

   // response tdata: kind, message, time, pos h, pos v, level
   localparam int RSP_BITS   = KIND_W + 2 * WORD_W + 2 * POS_W + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;
   localparam int RSP_USER_W = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_POST  = 2'd0,
      ACT_GET   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] position;   // vertical in upper half
      logic [WORD_W-1:0] stamp;
      logic [WORD_W-1:0] message;
      logic [KIND_W-1:0] kind;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic              found;
      logic              status;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] message;
      logic [WORD_W-1:0] stamp;
      logic [POS_W-1:0]  pos_h;
      logic [POS_W-1:0]  pos_v;
      logic [CNT_W-1:0]  level;
   } rsp_type;

   function automatic logic [IDX_W-1:0] nxt_idx(input logic [IDX_W-1:0] i);
      if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mev_ram.sv @@
// ----------------------------------------------------------------------------
// mev_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mev_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/masked_event_queue.sv @@
// ----------------------------------------------------------------------------
// masked_event_queue: ring-buffer event queue with kind-masked get, peek and flush
// Post, get-next, peek and flush over one slot memory and a scan sequencer.
// ----------------------------------------------------------------------------
// usage
//   req channel: one request per action; req_tuser carries the action code,
//   req_tdata the event fields and masks. rsp channel: exactly one response
//   per request, with found/status in rsp_tuser and the event and level in
//   rsp_tdata.
// scans
//   post and any action on an empty queue answer on the accepting edge;
//   get, peek and flush walk the queue from the head, one slot per cycle
//   through the single slot memory port. req_tready is low while a scan
//   runs.
// reset
//   empties the queue (head, tail and count cleared) and drops any response;
//   slot contents are left as they are and are only read once written.
// stalls
//   a response waits in the output register; a new request is taken only
//   when that register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_event_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: kind_in, message_in, select_mask, stop_mask, tick_now,
   //            mouse_h, mouse_v, zero pad
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [mev_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: action
   input  wire logic [mev_pkg::ACT_W-1:0]       req_tuser,
   // rsp_tdata: kind_out, message_out, time_out, pos_h_out, pos_v_out,
   //            level, zero pad
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [mev_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: found, status
   output      logic [mev_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   localparam int IW = mev_pkg::IDX_W;
   localparam int CW = mev_pkg::CNT_W;
   localparam int WW = mev_pkg::WORD_W;
   localparam int PW = mev_pkg::POS_W;
   localparam int KW = mev_pkg::KIND_W;

   // request field unpacking
   logic [KW-1:0] req_kind;
   logic [WW-1:0] req_message;
   logic [WW-1:0] req_select;
   logic [WW-1:0] req_stop;
   logic [WW-1:0] req_tick;
   logic [PW-1:0] req_mouse_h;
   logic [PW-1:0] req_mouse_v;
   mev_pkg::action_type req_action;

   assign req_kind    = req_tdata[KW-1:0];
   assign req_message = req_tdata[KW +: WW];
   assign req_select  = req_tdata[KW + WW +: WW];
   assign req_stop    = req_tdata[KW + 2*WW +: WW];
   assign req_tick    = req_tdata[KW + 3*WW +: WW];
   assign req_mouse_h = req_tdata[KW + 4*WW +: PW];
   assign req_mouse_v = req_tdata[KW + 4*WW + PW +: PW];
   assign req_action  = mev_pkg::action_type'(req_tuser);

   mev_pkg::state_type  state_ff, state_in;
   mev_pkg::action_type act_ff, act_in;
   logic [WW-1:0] sel_ff, sel_in;
   logic [WW-1:0] stop_ff, stop_in;
   logic [WW-1:0] tick_ff, tick_in;
   logic [PW-1:0] mh_ff, mh_in;
   logic [PW-1:0] mv_ff, mv_in;

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] rd_ff, rd_in;
   logic [IW-1:0] wr_ff, wr_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] iter_ff, iter_in;
   logic          halted_ff, halted_in;

   logic             rsp_valid_ff, rsp_valid_in;
   mev_pkg::rsp_type rsp_ff, rsp_in;

   // slot memory port
   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   mev_pkg::slot_type ram_wdata;
   logic [IW-1:0]     ram_raddr;
   mev_pkg::slot_type ram_rdata;

   mev_ram #(
      .WIDTH (mev_pkg::SLOT_W),
      .DEPTH (mev_pkg::QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic accept;
   logic hit_sel;
   logic hit_stop;
   logic last;
   logic halt_now;
   logic keep;

   assign accept   = req_tvalid && req_tready;
   assign hit_sel  = sel_ff[ram_rdata.kind];
   assign hit_stop = stop_ff[ram_rdata.kind];
   assign last     = ((iter_ff + 1'b1) == count_ff);
   assign halt_now = halted_ff || hit_stop;
   assign keep     = halt_now || !hit_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mev_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      sel_ff    <= sel_in;
      stop_ff   <= stop_in;
      tick_ff   <= tick_in;
      mh_ff     <= mh_in;
      mv_ff     <= mv_in;
      rd_ff     <= rd_in;
      wr_ff     <= wr_in;
      kept_ff   <= kept_in;
      iter_ff   <= iter_in;
      halted_ff <= halted_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      sel_in       = sel_ff;
      stop_in      = stop_ff;
      tick_in      = tick_ff;
      mh_in        = mh_ff;
      mv_in        = mv_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      kept_in      = kept_ff;
      iter_in      = iter_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = head_ff;

      case (state_ff)
         mev_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (accept) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               if (req_action == mev_pkg::ACT_POST) begin
                  if (count_ff == CW'(mev_pkg::QUEUE_DEPTH)) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     ram_we             = 1'b1;
                     ram_waddr          = tail_ff;
                     ram_wdata.kind     = req_kind;
                     ram_wdata.message  = req_message;
                     ram_wdata.stamp    = req_tick;
                     ram_wdata.position = {req_mouse_v, req_mouse_h};
                     tail_in            = mev_pkg::nxt_idx(tail_ff);
                     count_in           = count_ff + 1'b1;
                  end
                  rsp_in.level = count_in;
               end else if (count_ff == '0) begin
                  // empty queue: null event, flush leaves everything zero
                  if (req_action != mev_pkg::ACT_FLUSH) begin
                     rsp_in.stamp = req_tick;
                     rsp_in.pos_h = req_mouse_h;
                     rsp_in.pos_v = req_mouse_v;
                  end
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = mev_pkg::ST_SCAN;
                  act_in       = req_action;
                  sel_in       = req_select;
                  stop_in      = req_stop;
                  tick_in      = req_tick;
                  mh_in        = req_mouse_h;
                  mv_in        = req_mouse_v;
                  rd_in        = head_ff;
                  wr_in        = head_ff;
                  kept_in      = '0;
                  iter_in      = '0;
                  halted_in    = 1'b0;
               end
            end
         end

         mev_pkg::ST_SCAN: begin
            // ram_rdata holds slot rd_ff; fetch the following slot meanwhile
            ram_raddr = mev_pkg::nxt_idx(rd_ff);
            rd_in     = mev_pkg::nxt_idx(rd_ff);
            iter_in   = iter_ff + 1'b1;
            rsp_in    = '0;
            case (act_ff)
               mev_pkg::ACT_FLUSH: begin
                  halted_in = halt_now;
                  if (keep) begin
                     ram_we    = 1'b1;
                     ram_waddr = wr_ff;
                     wr_in     = mev_pkg::nxt_idx(wr_ff);
                     kept_in   = kept_ff + 1'b1;
                  end
                  if (last) begin
                     count_in     = kept_in;
                     tail_in      = wr_in;
                     rsp_in.level = kept_in;
                     rsp_valid_in = 1'b1;
                     state_in     = mev_pkg::ST_IDLE;
                  end
               end
               default: begin
                  if (hit_sel) begin
                     if (act_ff == mev_pkg::ACT_GET) begin
                        head_in  = mev_pkg::nxt_idx(head_ff);
                        count_in = count_ff - 1'b1;
                     end
                     rsp_in.found   = 1'b1;
                     rsp_in.kind    = ram_rdata.kind;
                     rsp_in.message = ram_rdata.message;
                     rsp_in.stamp   = ram_rdata.stamp;
                     rsp_in.pos_h   = ram_rdata.position[PW-1:0];
                     rsp_in.pos_v   = ram_rdata.position[WW-1:PW];
                     rsp_in.level   = count_in;
                     rsp_valid_in   = 1'b1;
                     state_in       = mev_pkg::ST_IDLE;
                  end else begin
                     if (act_ff == mev_pkg::ACT_GET) begin
                        // rotate the head slot to the back
                        ram_we    = 1'b1;
                        ram_waddr = tail_ff;
                        tail_in   = mev_pkg::nxt_idx(tail_ff);
                        head_in   = mev_pkg::nxt_idx(head_ff);
                     end
                     if (last) begin
                        rsp_in.stamp = tick_ff;
                        rsp_in.pos_h = mh_ff;
                        rsp_in.pos_v = mv_ff;
                        rsp_in.level = count_ff;
                        rsp_valid_in = 1'b1;
                        state_in     = mev_pkg::ST_IDLE;
                     end
                  end
               end
            endcase
         end

         default: begin
            state_in = mev_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.found};
   assign rsp_tdata  = {{mev_pkg::RSP_PAD_W{1'b0}}, rsp_ff.level, rsp_ff.pos_v,
                        rsp_ff.pos_h, rsp_ff.stamp, rsp_ff.message, rsp_ff.kind};

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mev_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mev_pkg::ST_SCAN) |-> !req_tready)
      else $error("request taken during scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mev_pkg::ST_SCAN) |-> (iter_ff < count_ff))
      else $error("scan ran past the held events");

   a_peek_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mev_pkg::ST_SCAN && act_ff == mev_pkg::ACT_PEEK) |-> !ram_we)
      else $error("peek modified the queue");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mev_pkg::ST_SCAN) |-> !rsp_valid_ff)
      else $error("response pending while scanning");

endmodule

`default_nettype wire
